FILE: hw/rtl/deh_pkg.sv
package deh_pkg;

  // Input command codes
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Result kinds
  localparam logic KIND_EVENT   = 1'b0;
  localparam logic KIND_READOUT = 1'b1;

  // Header block type that carries individual trigger events
  localparam logic [3:0] TRIG_BLOCK_TYPE = 4'h2;

  // Histogram geometry and count limit
  localparam int          BIN_IDX_W   = 10;
  localparam int          BINS_PER_CH = 1 << BIN_IDX_W;
  localparam int          ENERGY_W    = 16;
  localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

  // Output queue
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = 3;
  localparam int OUT_CNT_W = 4;

  typedef struct packed {
    logic        result_kind;
    logic [6:0]  channel;
    logic        special_flag;
    logic [47:0] coarse_timestamp;
    logic        waveform_flag;
    logic [9:0]  flags_low;
    logic [7:0]  flags_high;
    logic [15:0] short_energy;
    logic [15:0] fine_time;
    logic [15:0] energy_value;
    logic [31:0] bin_count;
  } res_t;

  typedef struct packed {
    logic                 valid;
    logic                 is_read;
    logic [5:0]           rd_channel;
    logic [BIN_IDX_W-1:0] rd_bin;
    res_t                 res;
  } hist_req_t;

  typedef struct packed {
    logic       clearing;
    logic [1:0] inflight;
  } hist_status_t;

endpackage

FILE: hw/rtl/digitizer_event_deframe_histogram_core.sv
// Deframes digitizer readout words and keeps a per-channel energy histogram.
// Takes one transaction per clock while in_stall is low: a stream word
// (command 0) or a bin read (command 1). Only individual trigger blocks are
// parsed; at each event end of two or more words an event result is returned
// and the bin energy / BIN_WIDTH (clamped to the overflow bin NUM_BINS) of
// that channel counts up, saturating. A bin read returns the stored count and
// sees every fill accepted before it. A result passes the request register,
// the product and update stages into the result queue. The memory has one
// write port, one registered read port; the last written count is forwarded
// to a read of the same bin in the cycle after it. An eight-entry queue
// decouples the output, so outside the clearing pass in_stall rises only when
// it would fill. After reset the memory is swept to zero, one bin a cycle,
// over NUM_CHANNELS * 1024 bins (65536 at the default), in_stall held high.
module digitizer_event_deframe_histogram_core #(
  parameter int NUM_CHANNELS = 64,
  parameter int NUM_BINS     = 1000,
  parameter int BIN_WIDTH    = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [63:0] data_word,
  input  logic        block_start,
  input  logic [5:0]  read_channel,
  input  logic [9:0]  read_bin,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [6:0]  channel,
  output logic        special_flag,
  output logic [47:0] coarse_timestamp,
  output logic        waveform_flag,
  output logic [9:0]  flags_low,
  output logic [7:0]  flags_high,
  output logic [15:0] short_energy,
  output logic [15:0] fine_time,
  output logic [15:0] energy_value,
  output logic [31:0] bin_count
);
  import deh_pkg::*;

  localparam int PEND_W = OUT_CNT_W + 1;

  logic                 accept;
  hist_req_t            req;
  logic                 res_valid;
  res_t                 res;
  hist_status_t         status;
  res_t                 head;
  logic [OUT_CNT_W-1:0] fifo_count;
  logic [PEND_W-1:0]    pending;

  // Reserve a queue slot for every transaction still in the pipeline
  assign pending  = PEND_W'(fifo_count) + PEND_W'(req.valid) + PEND_W'(status.inflight);
  assign in_stall = status.clearing || (pending >= PEND_W'(OUT_DEPTH));
  assign accept   = in_valid && !in_stall;

  deh_deframer u_deframer (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .command      (command),
    .data_word    (data_word),
    .block_start  (block_start),
    .read_channel (read_channel),
    .read_bin     (read_bin),
    .req          (req)
  );

  deh_hist #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .NUM_BINS     (NUM_BINS),
    .BIN_WIDTH    (BIN_WIDTH)
  ) u_hist (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  deh_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (!out_stall),
    .not_empty (out_valid),
    .head      (head),
    .count     (fifo_count)
  );

  // Drive result fields from the queue head
  assign result_kind      = head.result_kind;
  assign channel          = head.channel;
  assign special_flag     = head.special_flag;
  assign coarse_timestamp = head.coarse_timestamp;
  assign waveform_flag    = head.waveform_flag;
  assign flags_low        = head.flags_low;
  assign flags_high       = head.flags_high;
  assign short_energy     = head.short_energy;
  assign fine_time        = head.fine_time;
  assign energy_value     = head.energy_value;
  assign bin_count        = head.bin_count;

  a_pending_bound : assert property (@(posedge clk) disable iff (rst)
    pending <= PEND_W'(OUT_DEPTH))
    else $error("more transactions in flight than queue slots");

endmodule

FILE: hw/rtl/deh_deframer.sv
module deh_deframer (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               command,
  input  logic [63:0]        data_word,
  input  logic               block_start,
  input  logic [5:0]         read_channel,
  input  logic [9:0]         read_bin,
  output deh_pkg::hist_req_t req
);
  import deh_pkg::*;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_MORE   = 2'd2;

  logic        in_trig;
  logic        in_trig_next;
  logic [1:0]  word_pos;
  logic [1:0]  word_pos_next;
  logic [63:0] first_word;
  logic [63:0] first_word_next;
  logic [63:0] second_word;
  logic [63:0] second_word_next;
  logic        emit;
  logic        emit_read;
  logic [63:0] word_a;
  logic [63:0] word_b;
  res_t        res_next;

  logic        req_valid;
  logic        req_is_read;
  logic [5:0]  req_rd_channel;
  logic [9:0]  req_rd_bin;
  res_t        req_res;

  // Walk the stream: headers, event words and event ends
  always_comb begin
    in_trig_next     = in_trig;
    word_pos_next    = word_pos;
    first_word_next  = first_word;
    second_word_next = second_word;
    emit             = 1'b0;
    emit_read        = 1'b0;
    word_a           = first_word;
    word_b           = (word_pos == POS_SECOND) ? data_word : second_word;
    if (accept) begin
      if (command == CMD_READ) begin
        emit      = 1'b1;
        emit_read = 1'b1;
      end else if (block_start) begin
        in_trig_next  = (data_word[63:60] == TRIG_BLOCK_TYPE);
        word_pos_next = POS_FIRST;
      end else if (in_trig) begin
        if (word_pos == POS_FIRST) begin
          first_word_next = data_word;
        end else if (word_pos == POS_SECOND) begin
          second_word_next = data_word;
        end
        if (!data_word[63]) begin
          if (word_pos != POS_MORE) begin
            word_pos_next = word_pos + 2'd1;
          end
        end else if (word_pos != POS_FIRST) begin
          // event end with at least two words: decode it
          word_pos_next = POS_FIRST;
          emit          = 1'b1;
        end
      end
    end
  end

  // Decode the two leading event words, or build an empty readout
  always_comb begin
    res_next = '0;
    if (emit_read) begin
      res_next.result_kind = KIND_READOUT;
    end else begin
      res_next.result_kind      = KIND_EVENT;
      res_next.channel          = word_a[62:56];
      res_next.special_flag     = word_a[55];
      res_next.coarse_timestamp = word_a[47:0];
      res_next.waveform_flag    = word_b[62];
      res_next.flags_low        = word_b[59:50];
      res_next.flags_high       = word_b[49:42];
      res_next.short_energy     = word_b[41:26];
      res_next.fine_time        = word_b[31:16];
      res_next.energy_value     = word_b[15:0];
    end
  end

  // Hold stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_trig   <= 1'b0;
      word_pos  <= POS_FIRST;
      req_valid <= 1'b0;
    end else begin
      in_trig   <= in_trig_next;
      word_pos  <= word_pos_next;
      req_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    first_word  <= first_word_next;
    second_word <= second_word_next;
    if (emit) begin
      req_is_read    <= emit_read;
      req_rd_channel <= read_channel;
      req_rd_bin     <= read_bin;
      req_res        <= res_next;
    end
  end

  assign req.valid      = req_valid;
  assign req.is_read    = req_is_read;
  assign req.rd_channel = req_rd_channel;
  assign req.rd_bin     = req_rd_bin;
  assign req.res        = req_res;

endmodule

FILE: hw/rtl/deh_hist.sv
module deh_hist #(
  parameter int NUM_CHANNELS = 64,
  parameter int NUM_BINS     = 1000,
  parameter int BIN_WIDTH    = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  deh_pkg::hist_req_t    req,
  output logic                  res_valid,
  output deh_pkg::res_t         res,
  output deh_pkg::hist_status_t status
);
  import deh_pkg::*;

  localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ADDR_W    = CH_W + BIN_IDX_W;
  localparam int MEM_DEPTH = NUM_CHANNELS * BINS_PER_CH;
  // Divide by BIN_WIDTH as multiply by a rounded-up reciprocal, exact for 16-bit energies
  localparam int     DIV_SHIFT  = ENERGY_W + $clog2(BIN_WIDTH);
  localparam longint DIV_RECIP  = ((longint'(1) << DIV_SHIFT) + BIN_WIDTH - 1) / BIN_WIDTH;
  localparam int     RECIP_W    = ENERGY_W + 1;
  localparam int     PROD_W     = ENERGY_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(DIV_RECIP);

  logic [31:0] mem [MEM_DEPTH];

  // Clearing pass
  logic              clearing;
  logic [ADDR_W-1:0] clear_addr;

  // Stage 2: quotient product
  hist_req_t         s2_req;
  logic [PROD_W-1:0] s2_prod;
  logic [PROD_W-1:0] s2_quot;
  logic [BIN_IDX_W-1:0] s2_bin;
  logic [6:0]        s2_ch;
  logic              s2_ch_ok;
  logic              s2_fill;
  logic              s2_hit;
  logic [ADDR_W-1:0] s2_addr;

  // Stage 3: read data back, modify and write
  logic              s3_valid;
  hist_req_t         s3_req;
  logic [ADDR_W-1:0] s3_addr;
  logic              s3_fill;
  logic              s3_hit;
  logic [31:0]       rd_data;
  logic [31:0]       cur_count;
  logic [31:0]       inc_count;

  // Last fill written, for the read that raced it
  logic              last_wr_valid;
  logic [ADDR_W-1:0] last_wr_addr;
  logic [31:0]       last_wr_data;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [31:0]       mem_wd;

  // Sweep the store to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == ADDR_W'(MEM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Register the energy times reciprocal
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_req.valid <= 1'b0;
    end else begin
      s2_req.valid <= req.valid;
    end
    s2_req.is_read    <= req.is_read;
    s2_req.rd_channel <= req.rd_channel;
    s2_req.rd_bin     <= req.rd_bin;
    s2_req.res        <= req.res;
    s2_prod           <= PROD_W'(req.res.energy_value) * PROD_W'(RECIP_V);
  end

  // Pick bin and address, check range
  always_comb begin
    s2_quot  = s2_prod >> DIV_SHIFT;
    s2_ch    = s2_req.is_read ? {1'b0, s2_req.rd_channel} : s2_req.res.channel;
    s2_ch_ok = ({1'b0, s2_ch} < 8'(NUM_CHANNELS));
    if (s2_req.is_read) begin
      s2_bin = s2_req.rd_bin;
    end else if (s2_quot > PROD_W'(NUM_BINS)) begin
      s2_bin = BIN_IDX_W'(NUM_BINS);
    end else begin
      s2_bin = s2_quot[BIN_IDX_W-1:0];
    end
    s2_fill = !s2_req.is_read && s2_ch_ok;
    s2_hit  = s2_req.is_read && s2_ch_ok && (s2_req.rd_bin <= BIN_IDX_W'(NUM_BINS));
    s2_addr = {s2_ch[CH_W-1:0], s2_bin};
  end

  // Advance to the update stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_req.valid;
    end
    s3_req  <= s2_req;
    s3_addr <= s2_addr;
    s3_fill <= s2_fill;
    s3_hit  <= s2_hit;
  end

  // Forward the last fill, then saturate the increment
  always_comb begin
    cur_count = (last_wr_valid && (last_wr_addr == s3_addr)) ? last_wr_data : rd_data;
    inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + 32'd1;
    mem_we    = clearing || (s3_valid && s3_fill);
    mem_wa    = clearing ? clear_addr : s3_addr;
    mem_wd    = clearing ? 32'd0 : inc_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_wr_valid <= 1'b0;
    end else if (s3_valid && s3_fill) begin
      last_wr_valid <= 1'b1;
    end
    if (s3_valid && s3_fill) begin
      last_wr_addr <= s3_addr;
      last_wr_data <= inc_count;
    end
  end

  // Histogram store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[s2_addr];
  end

  // Result
  always_comb begin
    res = s3_req.res;
    if (s3_req.is_read) begin
      res.bin_count = s3_hit ? cur_count : 32'd0;
    end
  end

  assign res_valid       = s3_valid;
  assign status.clearing = clearing;
  assign status.inflight = 2'(s2_req.valid) + 2'(s3_valid);

  a_no_work_while_clearing : assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!s2_req.valid && !s3_valid))
    else $error("transaction in flight during clearing pass");

  a_fill_in_range : assert property (@(posedge clk) disable iff (rst)
    (s3_valid && s3_fill) |-> ({1'b0, s3_addr} < (ADDR_W + 1)'(MEM_DEPTH)))
    else $error("fill address beyond histogram store");

  a_event_no_count : assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.result_kind == KIND_EVENT)) |-> (res.bin_count == 32'd0))
    else $error("event result carries a bin count");

endmodule

FILE: hw/rtl/deh_out_fifo.sv
module deh_out_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  deh_pkg::res_t                   push_data,
  input  logic                            pop,
  output logic                            not_empty,
  output deh_pkg::res_t                   head,
  output logic [deh_pkg::OUT_CNT_W-1:0]   count
);
  import deh_pkg::*;

  res_t                 entries [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic                 do_pop;

  assign do_pop    = pop && (count != '0);
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + OUT_CNT_W'(push) - OUT_CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    push |-> (count < OUT_CNT_W'(OUT_DEPTH)) || do_pop)
    else $error("result queue overflow");

endmodule
